// ===== hdl/rle_pkg.sv =====
// Shared types and constants for the run-length encoder.
package rle_pkg;

  localparam int SAMPLE_W = 16;
  localparam int RUN_W    = 16;

  // A run emits literals until it holds this many samples.
  localparam logic [RUN_W:0] RUN_LITERALS = 17'd3;

  // Output queue geometry.
  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = 2;
  localparam int QCNT_W      = 3;
  // A sample may be encoded only while the queue holds at most this many words.
  localparam logic [QCNT_W-1:0] QUEUE_ROOM_MAX = 3'd2;

  // Number of words one sample pushes into the queue.
  localparam logic [1:0] PUSH_NONE = 2'd0;
  localparam logic [1:0] PUSH_ONE  = 2'd1;
  localparam logic [1:0] PUSH_TWO  = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] code_word;
    logic                       is_repeat_count;
    logic                       last_word;
  } code_t;

  typedef struct packed {
    logic [1:0] num;
    code_t      w0;
    code_t      w1;
  } push_t;

endpackage

// ===== hdl/rle_channels.sv =====
// Handshake channel interfaces for the sample input and the code word output.
interface rle_sample_if import rle_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic                       end_of_stream;

  modport source (output valid, output sample_value, output end_of_stream, input ready);
  modport sink   (input valid, input sample_value, input end_of_stream, output ready);
endinterface

interface rle_code_if import rle_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] code_word;
  logic                       is_repeat_count;
  logic                       last_word;

  modport source (output valid, output code_word, output is_repeat_count,
                  output last_word, input ready);
  modport sink   (input valid, input code_word, input is_repeat_count,
                  input last_word, output ready);
endinterface

// ===== hdl/run_length_encoder_unit.sv =====
// Run-length encoder: samples in, literal and repeat-count words out.
//
// samples channel: one signed 16-bit sample per word, end_of_stream on the
// final sample of a stream. codes channel: literal samples and repeat-count
// words (count minus three, capped at MAX_EXTRA), last_word on the final
// word of a stream.
// A sample is caught in an input register; once the queue has room it is
// encoded and its zero, one or two words are written into a four-word
// queue, whose oldest word drives codes.
// One sample is accepted every cycle while the queue holds two or fewer
// words; the queue drains one word per cycle while codes.ready is high,
// so a sample ending a long run (count word plus literal) can stall input.
// A receiver stall fills the queue and then holds the input register,
// dropping samples.ready; nothing is lost.
// Reset (synchronous, rst high) empties the queue and input register and
// clears the run state, so the next sample starts a new stream.
module run_length_encoder_unit import rle_pkg::*; #(
  parameter int MAX_EXTRA = 32767
) (
  input  logic       clk,
  input  logic       rst,
  rle_sample_if.sink samples,
  rle_code_if.source codes
);

  push_t push;
  logic  room;

  rle_core #(
    .MAX_EXTRA (MAX_EXTRA)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .room    (room),
    .push    (push)
  );

  rle_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .room  (room),
    .codes (codes)
  );

endmodule

// ===== hdl/rle_core.sv =====
// Input register, run tracking state and the per-sample encode logic.
module rle_core import rle_pkg::*; #(
  parameter int MAX_EXTRA = 32767
) (
  input  logic         clk,
  input  logic         rst,
  rle_sample_if.sink   samples,
  input  logic         room,
  output push_t        push
);

  localparam logic [RUN_W:0] CAP_COUNT = (RUN_W+1)'(MAX_EXTRA + 3);
  localparam logic signed [SAMPLE_W-1:0] CAP_WORD = SAMPLE_W'(MAX_EXTRA);

  // input register
  logic                       held;
  logic signed [SAMPLE_W-1:0] held_sample;
  logic                       held_eos;

  // run state
  logic signed [SAMPLE_W-1:0] previous_sample;
  logic [RUN_W-1:0]           run_length;
  logic                       stream_started;

  logic           fire;
  logic [RUN_W:0] cnt_inc;
  logic [RUN_W:0] cnt_next;
  code_t          lit;
  code_t          cnt_word;
  push_t          words;

  assign fire          = held && room;
  assign samples.ready = !held || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (samples.ready) begin
      held <= samples.valid;
    end
    if (samples.ready && samples.valid) begin
      held_sample <= samples.sample_value;
      held_eos    <= samples.end_of_stream;
    end
  end

  assign cnt_inc = {1'b0, run_length} + 17'd1;

  always_comb begin
    lit      = '{code_word: held_sample, is_repeat_count: 1'b0, last_word: 1'b0};
    cnt_word = '{code_word: '0, is_repeat_count: 1'b1, last_word: 1'b0};
    words    = '{num: PUSH_NONE, w0: lit, w1: lit};
    cnt_next = {1'b0, run_length};
    if (!stream_started || run_length == '0) begin
      words.num = PUSH_ONE;
      cnt_next  = 17'd1;
    end else if (held_sample == previous_sample) begin
      if (cnt_inc >= CAP_COUNT) begin
        // run hit the cap: flush it, next sample is a literal
        cnt_word.code_word = CAP_WORD;
        words.w0  = cnt_word;
        words.num = PUSH_ONE;
        cnt_next  = '0;
      end else begin
        cnt_next = cnt_inc;
        if (cnt_inc <= RUN_LITERALS) begin
          words.num = PUSH_ONE;
        end
        if (held_eos && cnt_inc >= RUN_LITERALS) begin
          cnt_word.code_word = SAMPLE_W'(cnt_inc - RUN_LITERALS);
          if (words.num == PUSH_ONE) begin
            words.w1  = cnt_word;
            words.num = PUSH_TWO;
          end else begin
            words.w0  = cnt_word;
            words.num = PUSH_ONE;
          end
        end
      end
    end else begin
      cnt_next = 17'd1;
      if ({1'b0, run_length} >= RUN_LITERALS) begin
        cnt_word.code_word = SAMPLE_W'({1'b0, run_length} - RUN_LITERALS);
        words.w0  = cnt_word;
        words.w1  = lit;
        words.num = PUSH_TWO;
      end else begin
        words.num = PUSH_ONE;
      end
    end
    if (held_eos) begin
      if (words.num == PUSH_TWO) begin
        words.w1.last_word = 1'b1;
      end else begin
        words.w0.last_word = 1'b1;
      end
    end
    push = words;
    if (!fire) begin
      push.num = PUSH_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_sample <= '0;
      run_length      <= '0;
      stream_started  <= 1'b0;
    end else if (fire) begin
      if (held_eos) begin
        previous_sample <= '0;
        run_length      <= '0;
        stream_started  <= 1'b0;
      end else begin
        previous_sample <= held_sample;
        run_length      <= cnt_next[RUN_W-1:0];
        stream_started  <= 1'b1;
      end
    end
  end

endmodule

// ===== hdl/rle_queue.sv =====
// Four-word output queue taking up to two words per cycle, one out per cycle while codes.ready is high.
module rle_queue import rle_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  push_t      push,
  output logic       room,
  rle_code_if.source codes
);

  code_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              pop;
  code_t             head;

  assign room  = count <= QUEUE_ROOM_MAX;
  assign pop   = codes.valid && codes.ready;
  assign head  = mem[rd_ptr];

  assign codes.valid           = count != '0;
  assign codes.code_word       = head.code_word;
  assign codes.is_repeat_count = head.is_repeat_count;
  assign codes.last_word       = head.last_word;

  always_ff @(posedge clk) begin
    if (push.num != PUSH_NONE) begin
      mem[wr_ptr] <= push.w0;
    end
    if (push.num == PUSH_TWO) begin
      mem[wr_ptr + PTR_W'(1)] <= push.w1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.num);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + QCNT_W'(push.num) - QCNT_W'(pop);
    end
  end

endmodule

// ===== sim/tb_run_length_encoder_unit.sv =====
// Self-checking testbench for the run-length encoder: directed table and random streams.
module tb_run_length_encoder_unit;
  import rle_pkg::*;

  localparam int CAP          = 32767;
  localparam int PREDICTED    = -1;
  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       eos;
    int                         n;     // PREDICTED, or number of typed-in words
    code_t                      w0;
    code_t                      w1;
  } stim_row_t;

  logic clk;
  logic rst;

  rle_sample_if sample_bus ();
  rle_code_if   code_bus ();

  run_length_encoder_unit #(.MAX_EXTRA(CAP)) u_top (
    .clk     (clk),
    .rst     (rst),
    .samples (sample_bus),
    .codes   (code_bus)
  );

  // encoder model state
  logic signed [SAMPLE_W-1:0] enc_prev;
  int unsigned                enc_run;
  logic                       enc_started;

  code_t     pending_codes[$];
  stim_row_t cur_row;
  stim_row_t dir_rows[$];
  int        err_count;
  int        burst_left;
  int        idle_cycles;

  function automatic code_t lit_word(input logic signed [SAMPLE_W-1:0] v, input logic last);
    code_t w;
    w.code_word       = v;
    w.is_repeat_count = 1'b0;
    w.last_word       = last;
    return w;
  endfunction

  function automatic code_t count_word(input int unsigned extra, input logic last);
    code_t w;
    w.code_word       = SAMPLE_W'(extra);
    w.is_repeat_count = 1'b1;
    w.last_word       = last;
    return w;
  endfunction

  function automatic stim_row_t row(input logic signed [SAMPLE_W-1:0] s, input logic eos,
                                    input int n, input code_t w0 = '0, input code_t w1 = '0);
    stim_row_t r;
    r.sample = s;
    r.eos    = eos;
    r.n      = n;
    r.w0     = w0;
    r.w1     = w1;
    return r;
  endfunction

  // Encodes one sample, returns the number of words it yields.
  function automatic int encode_sample(input logic signed [SAMPLE_W-1:0] s, input logic eos,
                                       output code_t w0, output code_t w1);
    code_t       words[2];
    int          k;
    int unsigned cnt;
    k   = 0;
    cnt = enc_run;
    words[0] = '0;
    words[1] = '0;
    if (!enc_started || cnt == 0) begin
      words[k++] = lit_word(s, 1'b0);
      cnt = 1;
    end else if (s == enc_prev) begin
      cnt++;
      if (cnt < 4) words[k++] = lit_word(s, 1'b0);
      if (cnt >= 3 && cnt - 3 >= CAP) begin
        words[k++] = count_word(CAP, 1'b0);
        cnt = 0;
      end
    end else begin
      if (cnt > 2) words[k++] = count_word(cnt - 3, 1'b0);
      words[k++] = lit_word(s, 1'b0);
      cnt = 1;
    end
    enc_prev    = s;
    enc_run     = cnt;
    enc_started = 1'b1;
    if (eos) begin
      if (cnt > 2) words[k++] = count_word(cnt - 3, 1'b0);
      words[k-1].last_word = 1'b1;
      enc_prev    = '0;
      enc_run     = 0;
      enc_started = 1'b0;
    end
    w0 = words[0];
    w1 = words[1];
    return k;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: switches between free flow, random stalls and heavy back-pressure
  initial begin
    int mode;
    int mode_left;
    mode      = 0;
    mode_left = 0;
    code_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        code_bus.ready = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          0:       code_bus.ready = 1'b1;
          1:       code_bus.ready = $urandom_range(0, 1);
          default: code_bus.ready = ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // predict on accepted samples, check accepted code words
  always @(posedge clk) begin
    code_t got;
    code_t want;
    code_t p0;
    code_t p1;
    int    n;
    if (!rst) begin
      if (sample_bus.valid && sample_bus.ready) begin
        n = encode_sample(sample_bus.sample_value, sample_bus.end_of_stream, p0, p1);
        if (cur_row.n != PREDICTED) begin
          n  = cur_row.n;
          p0 = cur_row.w0;
          p1 = cur_row.w1;
        end
        if (n > 0) pending_codes.push_back(p0);
        if (n > 1) pending_codes.push_back(p1);
      end
      if (code_bus.valid && code_bus.ready) begin
        got.code_word       = code_bus.code_word;
        got.is_repeat_count = code_bus.is_repeat_count;
        got.last_word       = code_bus.last_word;
        if (pending_codes.size() == 0) begin
          $error("unexpected word: code_word %0d, is_repeat_count %0b, last_word %0b",
                 got.code_word, got.is_repeat_count, got.last_word);
          err_count++;
        end else begin
          want = pending_codes.pop_front();
          if (got.code_word !== want.code_word) begin
            $error("code_word: expected %0d, got %0d", want.code_word, got.code_word);
            err_count++;
          end
          if (got.is_repeat_count !== want.is_repeat_count) begin
            $error("is_repeat_count: expected %0b, got %0b",
                   want.is_repeat_count, got.is_repeat_count);
            err_count++;
          end
          if (got.last_word !== want.last_word) begin
            $error("last_word: expected %0b, got %0b", want.last_word, got.last_word);
            err_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((sample_bus.valid && sample_bus.ready) || (code_bus.valid && code_bus.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_run_length_encoder_unit failed");
        $finish;
      end
    end
  end

  // sender works in bursts; valid stays high between back-to-back words
  task automatic send_row(input stim_row_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        sample_bus.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    cur_row                  = r;
    sample_bus.valid         = 1'b1;
    sample_bus.sample_value  = r.sample;
    sample_bus.end_of_stream = r.eos;
    @(posedge clk);
    while (!sample_bus.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    sample_bus.valid = 1'b0;
    while (pending_codes.size() != 0) @(negedge clk);
  endtask

  // streams of runs with random values; short runs dominate, some long ones
  task automatic random_traffic(input int n_items);
    logic signed [SAMPLE_W-1:0] v;
    int run_left;
    int stream_left;
    v           = '0;
    run_left    = 0;
    stream_left = 0;
    for (int i = 0; i < n_items; i++) begin
      if (stream_left == 0)
        stream_left = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 60);
      if (run_left == 0) begin
        case ($urandom_range(0, 3))
          0:       v = SAMPLE_W'($urandom);
          1:       v = SAMPLE_W'(int'($urandom_range(0, 3)) - 2);
          2:       v = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
          default: ;  // same value again: merges into the previous run
        endcase
        run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 4);
      end
      send_row(row(v, (stream_left == 1) || (i == n_items - 1), PREDICTED));
      run_left--;
      stream_left--;
    end
  endtask

  initial begin
    rst                      = 1'b1;
    sample_bus.valid         = 1'b0;
    sample_bus.sample_value  = '0;
    sample_bus.end_of_stream = 1'b0;
    cur_row                  = row('0, 1'b0, PREDICTED);
    enc_prev                 = '0;
    enc_run                  = 0;
    enc_started              = 1'b0;
    err_count                = 0;
    burst_left               = 0;
    idle_cycles              = 0;

    // first sample equals the cleared previous sample, still a literal
    dir_rows.push_back(row(16'sh0000, 1'b0, 1, lit_word(16'sh0000, 1'b0)));
    dir_rows.push_back(row(16'sh0000, 1'b0, 1, lit_word(16'sh0000, 1'b0)));
    dir_rows.push_back(row(16'sh0000, 1'b0, 1, lit_word(16'sh0000, 1'b0)));
    dir_rows.push_back(row(16'sh0000, 1'b1, 1, count_word(1, 1'b1)));
    // one-sample streams at the extremes
    dir_rows.push_back(row(16'sh7fff, 1'b1, 1, lit_word(16'sh7fff, 1'b1)));
    dir_rows.push_back(row(16'sh8000, 1'b1, 1, lit_word(16'sh8000, 1'b1)));
    // run of exactly three at end: count 0 carries last
    dir_rows.push_back(row(16'sd5, 1'b0, 1, lit_word(16'sd5, 1'b0)));
    dir_rows.push_back(row(16'sd5, 1'b0, 1, lit_word(16'sd5, 1'b0)));
    dir_rows.push_back(row(16'sd5, 1'b1, 2, lit_word(16'sd5, 1'b0), count_word(0, 1'b1)));
    // run of four broken by the final sample: count word then literal
    dir_rows.push_back(row(16'sh5555, 1'b0, 1, lit_word(16'sh5555, 1'b0)));
    dir_rows.push_back(row(16'sh5555, 1'b0, 1, lit_word(16'sh5555, 1'b0)));
    dir_rows.push_back(row(16'sh5555, 1'b0, 1, lit_word(16'sh5555, 1'b0)));
    dir_rows.push_back(row(16'sh5555, 1'b0, 0));
    dir_rows.push_back(row(16'shaaaa, 1'b1, 2, count_word(1, 1'b0), lit_word(16'shaaaa, 1'b1)));
    // run of two gets no count word
    dir_rows.push_back(row(16'sd7, 1'b0, PREDICTED));
    dir_rows.push_back(row(16'sd7, 1'b0, PREDICTED));
    dir_rows.push_back(row(16'sd8, 1'b0, PREDICTED));
    // run of five mid-stream, then a run of two at the end
    dir_rows.push_back(row(-16'sd1, 1'b0, PREDICTED));
    dir_rows.push_back(row(-16'sd1, 1'b0, PREDICTED));
    dir_rows.push_back(row(-16'sd1, 1'b0, PREDICTED));
    dir_rows.push_back(row(-16'sd1, 1'b0, PREDICTED));
    dir_rows.push_back(row(-16'sd1, 1'b0, PREDICTED));
    dir_rows.push_back(row(16'sd3, 1'b0, PREDICTED));
    dir_rows.push_back(row(16'sd3, 1'b1, PREDICTED));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) send_row(dir_rows[i]);
    hold_until_drained();

    random_traffic(390);
    hold_until_drained();

    random_traffic(390);

    sample_bus.valid = 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("tb_run_length_encoder_unit passed");
    else
      $display("tb_run_length_encoder_unit failed");
    $finish;
  end

endmodule
